### hw/rtl/twtd_pkg.sv
// ----------------------------------------------------------------------------
// twtd_pkg: shared types and constants of the wrap-tracking deadline timer
// Holds field widths, register indexes, command codes and the request and
// response bundles of the serial divider and multiplier.
// ----------------------------------------------------------------------------
package twtd_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned FREQ_W      = 30;   // 1e9 / period fits in 30 bits
    localparam int unsigned PERIOD_W    = 27;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned STEP_W      = 7;    // holds a step count up to 64
    localparam int unsigned DIV_STEPS   = 64;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0]   FS_SCALE     = 64'd1000000000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 27'd69841279;
    localparam logic [DATA_W-1:0]   MAX_NARROW   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0]   MAX_WIDE     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FS        = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTER_IS_64BIT = 4'd1;

    localparam logic CMD_READ     = 1'b0;
    localparam logic CMD_DEADLINE = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] multiplicand;
        logic [DATA_W-1:0] multiplier;
        logic [STEP_W-1:0] steps;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] product;
    } mul_rsp_t;

endpackage

### hw/rtl/twtd_if.sv
// ----------------------------------------------------------------------------
// twtd_if: channel interfaces of the wrap-tracking deadline timer
// Item, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface twtd_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] counter_value;
    logic [63:0] counter_after_write;
    logic [63:0] deadline_us;
    logic        deadline_infinite;

    modport source (
        output valid, command, counter_value, counter_after_write,
               deadline_us, deadline_infinite,
        input  ready
    );
    modport sink (
        input  valid, command, counter_value, counter_after_write,
               deadline_us, deadline_infinite,
        output ready
    );
endinterface

interface twtd_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] time_us;
    logic        comparator_write;
    logic [63:0] comparator_value;
    logic        deadline_armed;

    modport source (
        output valid, time_us, comparator_write, comparator_value, deadline_armed,
        input  ready
    );
    modport sink (
        input  valid, time_us, comparator_write, comparator_value, deadline_armed,
        output ready
    );
endinterface

interface twtd_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hw/rtl/twtd_div.sv
// ----------------------------------------------------------------------------
// twtd_div: bit-serial restoring divider
// Retires one quotient bit per cycle; pulses done with quotient and
// remainder held until the next start.
// ----------------------------------------------------------------------------
module twtd_div
    import twtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### hw/rtl/twtd_mul.sv
// ----------------------------------------------------------------------------
// twtd_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle; the product wraps modulo 2^64.
// ----------------------------------------------------------------------------
module twtd_mul
    import twtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0] mc_reg, mc_next;
    logic [DATA_W-1:0] mr_reg, mr_next;
    logic [DATA_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mc_next   = mc_reg;
        mr_next   = mr_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            mc_next   = req.multiplicand;
            mr_next   = req.multiplier;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (mr_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[DATA_W-2:0], 1'b0};
            mr_next  = {1'b0, mr_reg[DATA_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mr_reg  <= mr_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

### hw/rtl/timer_wrap_tracking_deadline_top.sv
// ----------------------------------------------------------------------------
// timer_wrap_tracking_deadline_top: wrap-tracking deadline timer
// Turns counter samples into microseconds and programs comparator deadlines.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - register writes (index 0 tick period in fs, index 1
//            counter_is_64bit); always ready, write only while idle.
//   item   - one beat per time read or deadline command; taken only while
//            the sequencer is idle, so one item is in flight at a time.
//   result - exactly one beat per item, held in an output register.
// Arithmetic: divisions and multiplications run on a shared bit-serial
//   divider and a shared shift-add multiplier, one bit per cycle. A time
//   read divides the last sample by the frequency and adds the wrap count
//   times the wrap time; a deadline still ahead adds the tick multiply,
//   after the modulo division when it needs one, or saturates. An infinite
//   deadline goes straight to the result. The first item after reset or a
//   config write also derives the frequency and the wrap time (two more
//   divisions). The next item can be taken the cycle after a result loads.
// Reset: tick period 69841279 fs, 64-bit counter, last sample and wrap
//   count 0; the derived frequency is marked stale.
// Stall: a stalled receiver holds the result register; the following item
//   then waits in the final state, and the input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module timer_wrap_tracking_deadline_top
    import twtd_pkg::*;
#(
    parameter int unsigned WRAP_COUNT_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    twtd_cfg_if.sink      cfg,
    twtd_item_if.sink     item,
    twtd_result_if.source result
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_FDIV = 9'b000000010,
        ST_WDIV = 9'b000000100,
        ST_TDIV = 9'b000001000,
        ST_TMUL = 9'b000010000,
        ST_CHK  = 9'b000100000,
        ST_MDIV = 9'b001000000,
        ST_KMUL = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;

    // configuration and derived constants
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                is64_reg, is64_next;
    logic                const_valid_reg, const_valid_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [DATA_W-1:0]   wrap_us_reg, wrap_us_next;

    // architectural state
    logic [DATA_W-1:0]           last_reg, last_next;
    logic [WRAP_COUNT_WIDTH-1:0] wrap_count_reg, wrap_count_next;

    // item working registers
    logic              cmd_reg, cmd_next;
    logic [DATA_W-1:0] after_reg, after_next;
    logic [DATA_W-1:0] dl_reg, dl_next;
    logic [DATA_W-1:0] tq_reg, tq_next;
    logic [DATA_W-1:0] now_reg, now_next;
    logic [DATA_W-1:0] ticks_reg, ticks_next;
    logic              wr_reg, wr_next;
    logic              armed_reg, armed_next;

    // output register
    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] res_time_reg, res_time_next;
    logic              res_write_reg, res_write_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              res_armed_reg, res_armed_next;

    logic [DATA_W-1:0]   cnt_max;
    logic [PERIOD_W-1:0] period_eff;
    logic [DATA_W-1:0]   sample;
    logic                item_take;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    twtd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    twtd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign cnt_max    = is64_reg ? MAX_WIDE : MAX_NARROW;
    // a zero period counts as one femtosecond
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign sample     = item.counter_value & cnt_max;
    assign item.ready = (state_reg == ST_IDLE);
    assign item_take  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // route the shared divider and multiplier by state
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = last_reg;
        div_req.divisor  = DATA_W'(freq_reg);
        mul_req.start        = 1'b0;
        mul_req.multiplicand = wrap_us_reg;
        mul_req.multiplier   = DATA_W'(wrap_count_reg);
        mul_req.steps        = STEP_W'(WRAP_COUNT_WIDTH);
        unique case (state_reg)
            ST_FDIV:
            begin
                div_req.start    = launch_reg;
                div_req.dividend = FS_SCALE;
                div_req.divisor  = DATA_W'(period_eff);
            end
            ST_WDIV:
            begin
                div_req.start    = launch_reg;
                div_req.dividend = cnt_max;
            end
            ST_TDIV:
            begin
                div_req.start = launch_reg;
            end
            ST_MDIV:
            begin
                div_req.start    = launch_reg;
                div_req.dividend = dl_reg;
                div_req.divisor  = wrap_us_reg;
            end
            ST_TMUL:
            begin
                mul_req.start = launch_reg;
            end
            ST_KMUL:
            begin
                mul_req.start        = launch_reg;
                mul_req.multiplicand = DATA_W'(freq_reg);
                mul_req.multiplier   = dl_reg;
                mul_req.steps        = STEP_W'(DATA_W);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        period_next      = period_reg;
        is64_next        = is64_reg;
        const_valid_next = const_valid_reg;
        freq_next        = freq_reg;
        wrap_us_next     = wrap_us_reg;
        last_next        = last_reg;
        wrap_count_next  = wrap_count_reg;
        cmd_next         = cmd_reg;
        after_next       = after_reg;
        dl_next          = dl_reg;
        tq_next          = tq_reg;
        now_next         = now_reg;
        ticks_next       = ticks_reg;
        wr_next          = wr_reg;
        armed_next       = armed_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        res_time_next    = res_time_reg;
        res_write_next   = res_write_reg;
        res_value_next   = res_value_reg;
        res_armed_next   = res_armed_reg;

        // register writes; any write makes the derived constants stale
        if (cfg.valid && cfg.ready)
        begin
            const_valid_next = 1'b0;
            if (cfg.index == CFG_PERIOD_FS)
            begin
                period_next = cfg.data[PERIOD_W-1:0];
            end
            else if (cfg.index == CFG_COUNTER_IS_64BIT)
            begin
                is64_next = cfg.data[0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    cmd_next   = item.command;
                    after_next = item.counter_after_write & cnt_max;
                    dl_next    = item.deadline_us;
                    now_next   = '0;
                    ticks_next = '0;
                    wr_next    = 1'b0;
                    armed_next = 1'b0;
                    if ((item.command == CMD_DEADLINE) && item.deadline_infinite)
                    begin
                        // nothing to program; leave the state alone
                        armed_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // advance: a sample below the last one is a wrap
                        if (sample < last_reg)
                        begin
                            wrap_count_next = wrap_count_reg + 1'b1;
                        end
                        last_next  = sample;
                        state_next = const_valid_reg ? ST_TDIV : ST_FDIV;
                    end
                end
            end
            ST_FDIV:
            begin
                if (div_rsp.done)
                begin
                    freq_next  = div_rsp.quotient[FREQ_W-1:0];
                    state_next = ST_WDIV;
                end
            end
            ST_WDIV:
            begin
                if (div_rsp.done)
                begin
                    wrap_us_next     = div_rsp.quotient;
                    const_valid_next = 1'b1;
                    state_next       = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    tq_next    = div_rsp.quotient;
                    state_next = ST_TMUL;
                end
            end
            ST_TMUL:
            begin
                if (mul_rsp.done)
                begin
                    now_next   = tq_reg + mul_rsp.product;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                priority if (cmd_reg == CMD_READ)
                begin
                    state_next = ST_DONE;
                end
                else if (dl_reg <= now_reg)
                begin
                    // deadline already passed
                    state_next = ST_DONE;
                end
                else if ((wrap_us_reg != '0) && (dl_reg >= wrap_us_reg))
                begin
                    state_next = ST_MDIV;
                end
                else if (dl_reg > wrap_us_reg)
                begin
                    // tick count beyond the counter range: saturate
                    ticks_next = cnt_max;
                    wr_next    = 1'b1;
                    armed_next = after_reg < cnt_max;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_KMUL;
                end
            end
            ST_MDIV:
            begin
                if (div_rsp.done)
                begin
                    dl_next    = div_rsp.remainder;
                    state_next = ST_KMUL;
                end
            end
            ST_KMUL:
            begin
                if (mul_rsp.done)
                begin
                    ticks_next = mul_rsp.product;
                    wr_next    = 1'b1;
                    armed_next = after_reg < mul_rsp.product;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_time_next  = now_reg;
                    res_write_next = wr_reg;
                    res_value_next = ticks_reg;
                    res_armed_next = armed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pulse a start on every state change; only work states use it
    assign launch_next = (state_next != state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            launch_reg      <= 1'b0;
            period_reg      <= PERIOD_RESET;
            is64_reg        <= 1'b1;
            const_valid_reg <= 1'b0;
            last_reg        <= '0;
            wrap_count_reg  <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            launch_reg      <= launch_next;
            period_reg      <= period_next;
            is64_reg        <= is64_next;
            const_valid_reg <= const_valid_next;
            last_reg        <= last_next;
            wrap_count_reg  <= wrap_count_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg      <= freq_next;
        wrap_us_reg   <= wrap_us_next;
        cmd_reg       <= cmd_next;
        after_reg     <= after_next;
        dl_reg        <= dl_next;
        tq_reg        <= tq_next;
        now_reg       <= now_next;
        ticks_reg     <= ticks_next;
        wr_reg        <= wr_next;
        armed_reg     <= armed_next;
        res_time_reg  <= res_time_next;
        res_write_reg <= res_write_next;
        res_value_reg <= res_value_next;
        res_armed_reg <= res_armed_next;
    end

    assign result.valid            = res_valid_reg;
    assign result.time_us          = res_time_reg;
    assign result.comparator_write = res_write_reg;
    assign result.comparator_value = res_value_reg;
    assign result.deadline_armed   = res_armed_reg;

    // time conversion must never run on a stale frequency
    a_const_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TDIV) |-> const_valid_reg)
        else $error("time division started with stale frequency");

    // divider finishes only while a division state waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_FDIV || state_reg == ST_WDIV ||
                          state_reg == ST_TDIV || state_reg == ST_MDIV))
        else $error("divider result arrived outside a division state");

    // multiplier finishes only while a multiply state waits for it
    a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_TMUL || state_reg == ST_KMUL))
        else $error("multiplier result arrived outside a multiply state");

endmodule
